@@ design/emu_pkg.sv @@
// Shared types and constants for the encoder multi-turn unwrap block.
// Holds the sample, result and per-motor state word layouts. No dependencies.
`timescale 1ns / 1ps

package emu_pkg;

  localparam int MOTORS = 4;
  localparam int MOTOR_AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  localparam int ANGLE_W = 13;
  localparam int SPAN_W = 21;
  localparam int POS_W = 20;
  localparam int WRAP_W = 16;

  localparam logic [ANGLE_W-1:0] ZONE_LOW = 13'd2000;
  localparam logic [ANGLE_W-1:0] ZONE_HIGH = 13'd7000;
  localparam logic [SPAN_W-1:0] ONE_TURN = 21'd8192;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 21'd155648;

  typedef struct packed {
    logic [1:0]         motor_index;
    logic [ANGLE_W-1:0] angle;
  } sample_t;

  typedef struct packed {
    logic [POS_W-1:0]         sum_position;
    logic signed [WRAP_W-1:0] rollovers;
  } result_t;

  typedef struct packed {
    logic              ahead_armed;
    logic              ahead_crossed;
    logic              back_armed;
    logic              back_crossed;
    logic [SPAN_W-1:0] turn_base;
    logic [WRAP_W-1:0] wrap_count;
  } motor_state_t;

  localparam int STATE_W = $bits(motor_state_t);

endpackage

@@ design/encoder_multiturn_unwrap_top.sv @@
// Top level of the encoder multi-turn unwrap block.
// Depends on emu_pkg, emu_ram (per-motor state store) and emu_step (update logic).
`timescale 1ns / 1ps

//  Channel  | Signals                            | Word
//  ---------+------------------------------------+-------------------------------
//  sample   | sample_valid, sample_ready, sample | motor index and 13-bit angle
//  result   | result_valid, result_ready, result | unwrapped position, rollovers
//  cfg      | cfg_valid, cfg_ready, cfg_data     | turn_span register (21 bits)
//
// One sample word is taken every cycle unless stalled. The accepting edge reads the
// state RAM; the update stage writes the updated state back and loads the result word.
// A motor hit on consecutive words takes its state from the last-write bypass register.
// Reset presets the span register, clears all handshake state and the per-motor valid
// bits, so every motor reads as zero. With result_ready low the output word holds, one
// more sample waits in the update stage, and further samples are refused.

module encoder_multiturn_unwrap_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  emu_pkg::sample_t            sample,
  output logic                        result_valid,
  input  logic                        result_ready,
  output emu_pkg::result_t            result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [emu_pkg::SPAN_W-1:0]  cfg_data
);

  logic [emu_pkg::SPAN_W-1:0]   turn_span;
  logic [emu_pkg::MOTORS-1:0]   ent_valid;

  logic                         s1_valid;
  emu_pkg::sample_t             s1_item;
  logic                         s1_entv;
  logic [emu_pkg::MOTOR_AW-1:0] s1_addr;
  logic                         s1_fire;

  logic                         wb_valid;
  logic [emu_pkg::MOTOR_AW-1:0] wb_addr;
  emu_pkg::motor_state_t        wb_state;

  logic                         accept;
  logic [emu_pkg::MOTOR_AW-1:0] rd_addr;
  logic [emu_pkg::STATE_W-1:0]  rd_data;
  emu_pkg::motor_state_t        cur;
  emu_pkg::motor_state_t        nxt;
  emu_pkg::result_t             res;
  logic                         in_range;
  logic                         wr_en;

  // Configuration is accepted at any time; the register feeds the limit.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_span <= emu_pkg::SPAN_RESET;
    end else if (cfg_valid) begin
      turn_span <= cfg_data;
    end
  end

  // The update stage moves on when the output register is free or draining.
  assign s1_fire = s1_valid && (!result_valid || result_ready);
  assign sample_ready = !s1_valid || s1_fire;
  assign accept = sample_valid && sample_ready;
  assign rd_addr = emu_pkg::MOTOR_AW'(sample.motor_index);
  assign s1_addr = emu_pkg::MOTOR_AW'(s1_item.motor_index);

  emu_ram #(
    .WIDTH(emu_pkg::STATE_W),
    .DEPTH(emu_pkg::MOTORS)
  ) u_state_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s1_addr),
    .wdata(nxt),
    .re   (accept),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // The valid bit is sampled with the read so that it lines up with rd_data.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= sample;
      if (32'(sample.motor_index) < emu_pkg::MOTORS) begin
        s1_entv <= ent_valid[rd_addr];
      end else begin
        s1_entv <= 1'b0;
      end
    end
  end

  // The last write always holds the newest state of its motor, so a matching
  // address takes it in preference to the RAM word, which may predate it.
  always_comb begin
    if (wb_valid && wb_addr == s1_addr) begin
      cur = wb_state;
    end else if (s1_entv) begin
      cur = emu_pkg::motor_state_t'(rd_data);
    end else begin
      cur = '0;
    end
  end

  emu_step u_step (
    .sample   (s1_item),
    .cur      (cur),
    .turn_span(turn_span),
    .nxt      (nxt),
    .res      (res),
    .in_range (in_range)
  );

  assign wr_en = s1_fire && in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      wb_valid <= 1'b0;
    end else if (wr_en) begin
      ent_valid[s1_addr] <= 1'b1;
      wb_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wb_addr <= s1_addr;
      wb_state <= nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result <= res;
    end
  end

endmodule

@@ design/emu_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Standalone; sized by its WIDTH and DEPTH parameters.
`timescale 1ns / 1ps

module emu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/emu_step.sv @@
// Zone tracking and turn base update for one motor sample.
// Uses the types and constants of emu_pkg.
`timescale 1ns / 1ps

module emu_step (
  input  emu_pkg::sample_t                sample,
  input  emu_pkg::motor_state_t           cur,
  input  logic [emu_pkg::SPAN_W-1:0]      turn_span,
  output emu_pkg::motor_state_t           nxt,
  output emu_pkg::result_t                res,
  output logic                            in_range
);

  logic                         lo;
  logic                         hi;
  logic                         aa;
  logic                         ac;
  logic                         ba;
  logic                         bc;
  logic signed [emu_pkg::SPAN_W+1:0] base;
  logic [emu_pkg::SPAN_W-1:0]   limit;
  logic [emu_pkg::SPAN_W-1:0]   new_base;
  logic [emu_pkg::WRAP_W-1:0]   new_wrap;
  logic [emu_pkg::SPAN_W-1:0]   pos;

  assign in_range = (32'(sample.motor_index) < emu_pkg::MOTORS);

  always_comb begin
    lo = sample.angle < emu_pkg::ZONE_LOW;
    hi = sample.angle > emu_pkg::ZONE_HIGH;
    aa = cur.ahead_armed;
    ac = cur.ahead_crossed;
    ba = cur.back_armed;
    bc = cur.back_crossed;
    if (!lo && !hi) begin
      aa = 1'b0;
      ac = 1'b0;
      ba = 1'b0;
      bc = 1'b0;
    end else if (hi) begin
      aa = 1'b1;
    end else begin
      ba = 1'b1;
    end
    if (aa && lo) begin
      ac = 1'b1;
    end
    if (ba && hi) begin
      bc = 1'b1;
    end

    base = $signed({2'b00, cur.turn_base});
    if (aa && ac) begin
      base = base + $signed({2'b00, emu_pkg::ONE_TURN});
      aa = 1'b0;
      ac = 1'b0;
    end
    if (ba && bc) begin
      base = base - $signed({2'b00, emu_pkg::ONE_TURN});
      ba = 1'b0;
      bc = 1'b0;
    end

    limit = (turn_span >= emu_pkg::ONE_TURN) ? turn_span - emu_pkg::ONE_TURN : '0;
    new_base = base[emu_pkg::SPAN_W-1:0];
    new_wrap = cur.wrap_count;
    if (base < 0) begin
      new_base = limit;
      new_wrap = cur.wrap_count - 16'd1;
    end else if (base > $signed({2'b00, limit})) begin
      new_base = '0;
      new_wrap = cur.wrap_count + 16'd1;
    end

    nxt.ahead_armed = aa;
    nxt.ahead_crossed = ac;
    nxt.back_armed = ba;
    nxt.back_crossed = bc;
    nxt.turn_base = new_base;
    nxt.wrap_count = new_wrap;

    // Indexes past the motor count leave state alone and echo the angle.
    if (in_range) begin
      pos = new_base + {{(emu_pkg::SPAN_W-emu_pkg::ANGLE_W){1'b0}}, sample.angle};
      res.rollovers = $signed(new_wrap);
    end else begin
      pos = {{(emu_pkg::SPAN_W-emu_pkg::ANGLE_W){1'b0}}, sample.angle};
      res.rollovers = '0;
    end
    res.sum_position = pos[emu_pkg::POS_W-1:0];
  end

endmodule
